### design/sdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter package
// Shared widths, constants, register indexes and types of the drive pipeline.
// ----------------------------------------------------------------------------
package sdl_pkg;

  localparam int ERR_W       = 16;
  localparam int ABS_W       = ERR_W + 1;
  localparam int PM_W        = 23;
  localparam int PROP_RECIP_W = 24;
  localparam int PROP_SHIFT  = 30;
  localparam int Q_W         = 17;
  localparam int DRIVE_W     = 11;
  localparam int PWM_W       = 10;
  localparam int MAG_W       = 11;
  localparam int RAMP_W      = 16;
  localparam int RAMP_FRAC_W = 8;
  localparam int BYTE_W      = 8;

  // Reciprocal of 100 scaled by two to the power PROP_SHIFT, rounded up.
  localparam logic [PROP_RECIP_W-1:0] PROP_RECIP = 24'd10737419;

  localparam logic [PWM_W-1:0]          PWM_MAX      = 10'd1023;
  localparam logic signed [DRIVE_W-1:0] VALVE_CLAMP  = 11'sd250;
  localparam logic signed [DRIVE_W-1:0] VALVE_OFFSET = 11'sd128;
  localparam int                        VALVE_SHIFT  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PWM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PWM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PWM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VALVE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVER   = 3'd7;

  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 48;

  typedef struct packed {
    logic [BYTE_W-1:0] gain;
    logic [BYTE_W-1:0] low_pwm;
    logic [BYTE_W-1:0] high_pwm;
    logic [BYTE_W-1:0] min_pwm;
    logic [RAMP_W-1:0] ramp_rate;
    logic              invert_direction;
    logic              valve_mode;
    logic              driver_select;
  } cfg_t;

  typedef struct packed {
    logic [PWM_W-1:0]          display_value;
    logic                      right_written;
    logic [PWM_W-1:0]          pwm_right;
    logic [PWM_W-1:0]          pwm_left;
    logic                      direction_written;
    logic                      direction_level;
    logic signed [DRIVE_W-1:0] signed_drive;
  } out_t;

endpackage

### design/steering_drive_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter
// Proportional steering drive with an error-dependent limit, four stages.
// ----------------------------------------------------------------------------
// An input beat passes through the multiply, divide, limit and map register
// stages in that order before it leaves as a result beat.
// Throughput is one beat per cycle while m_axis_tready is high; each stage moves
// on whenever the stage after it is free, so a held result stalls only full stages.
// Reset clears the valid bits of all stages and returns the configuration registers
// to their defaults: all zero, except high_pwm, which becomes 255.
module steering_drive_limiter #(
  parameter int RAMP_SPAN_CENTIDEG = 300
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // angle_error[15:0]
  input  logic [sdl_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // signed_drive[10:0], direction_level[11], direction_written[12],
  // pwm_left[22:13], pwm_right[32:23], right_written[33],
  // display_value[43:34], zero fill[47:44]
  output logic [sdl_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AbsWRaw = $clog2(RAMP_SPAN_CENTIDEG);
  localparam int AbsW    = (AbsWRaw < 1) ? 1 : AbsWRaw;
  localparam int RqW     = AbsW + 2;
  localparam int RpW     = AbsW + sdl_pkg::RAMP_W;
  localparam int OutW    = $bits(sdl_pkg::out_t);

  sdl_pkg::cfg_t cfg_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [sdl_pkg::PM_W-1:0]          s1_pm;
  logic [RpW-1:0]                    s1_rp;
  logic                              s1_neg, s1_in_ramp;
  logic [sdl_pkg::Q_W-1:0]           s2_q;
  logic [RqW-1:0]                    s2_rq;
  logic                              s2_neg, s2_in_ramp;
  logic signed [sdl_pkg::DRIVE_W-1:0] s3_drive;
  sdl_pkg::out_t                     out_q;
  logic [sdl_pkg::DRIVE_W-1:0]       out_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain             <= '0;
      cfg_q.low_pwm          <= '0;
      cfg_q.high_pwm         <= '1;
      cfg_q.min_pwm          <= '0;
      cfg_q.ramp_rate        <= '0;
      cfg_q.invert_direction <= 1'b0;
      cfg_q.valve_mode       <= 1'b0;
      cfg_q.driver_select    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdl_pkg::CFG_GAIN:     cfg_q.gain             <= cfg_data_i[sdl_pkg::BYTE_W-1:0];
        sdl_pkg::CFG_LOW_PWM:  cfg_q.low_pwm          <= cfg_data_i[sdl_pkg::BYTE_W-1:0];
        sdl_pkg::CFG_HIGH_PWM: cfg_q.high_pwm         <= cfg_data_i[sdl_pkg::BYTE_W-1:0];
        sdl_pkg::CFG_MIN_PWM:  cfg_q.min_pwm          <= cfg_data_i[sdl_pkg::BYTE_W-1:0];
        sdl_pkg::CFG_RAMP:     cfg_q.ramp_rate        <= cfg_data_i[sdl_pkg::RAMP_W-1:0];
        sdl_pkg::CFG_INVERT:   cfg_q.invert_direction <= cfg_data_i[0];
        sdl_pkg::CFG_VALVE:    cfg_q.valve_mode       <= cfg_data_i[0];
        sdl_pkg::CFG_DRIVER:   cfg_q.driver_select    <= cfg_data_i[0];
      endcase
    end
  end

  assign rdy4 = ~v4_q | m_axis_tready;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  sdl_mul_stage #(
    .AbsW     (AbsW),
    .RampSpan (RAMP_SPAN_CENTIDEG)
  ) u_mul (
    .clk_i     (clk_i),
    .en_i      (rdy1),
    .err_i     (s_axis_tdata[sdl_pkg::ERR_W-1:0]),
    .cfg_i     (cfg_q),
    .pm_o      (s1_pm),
    .rp_o      (s1_rp),
    .neg_o     (s1_neg),
    .in_ramp_o (s1_in_ramp)
  );

  sdl_div_stage #(
    .AbsW (AbsW)
  ) u_div (
    .clk_i     (clk_i),
    .en_i      (rdy2),
    .pm_i      (s1_pm),
    .rp_i      (s1_rp),
    .neg_i     (s1_neg),
    .in_ramp_i (s1_in_ramp),
    .q_o       (s2_q),
    .rq_o      (s2_rq),
    .neg_o     (s2_neg),
    .in_ramp_o (s2_in_ramp)
  );

  sdl_limit_stage #(
    .AbsW (AbsW)
  ) u_limit (
    .clk_i     (clk_i),
    .en_i      (rdy3),
    .q_i       (s2_q),
    .rq_i      (s2_rq),
    .neg_i     (s2_neg),
    .in_ramp_i (s2_in_ramp),
    .cfg_i     (cfg_q),
    .drive_o   (s3_drive)
  );

  sdl_map_stage u_map (
    .clk_i   (clk_i),
    .en_i    (rdy4),
    .drive_i (s3_drive),
    .cfg_i   (cfg_q),
    .out_o   (out_q)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = sdl_pkg::TDATA_OUT_W'(out_q[OutW-1:0]);

  assign out_abs = out_q.signed_drive[sdl_pkg::DRIVE_W-1]
                 ? sdl_pkg::DRIVE_W'(-out_q.signed_drive)
                 : sdl_pkg::DRIVE_W'(out_q.signed_drive);

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted beat did not enter stage one");

  a_one_driver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.direction_written != out_q.right_written))
    else $error("both or neither driver outputs flagged");

  a_display_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.display_value == out_abs[sdl_pkg::PWM_W-1:0]))
    else $error("display value differs from drive magnitude");

  a_valve_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cfg_q.valve_mode |->
      (out_q.signed_drive >= 11'sd65 && out_q.signed_drive <= 11'sd190))
    else $error("valve duty out of range");

endmodule

### design/sdl_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter, stage one
// Takes the error magnitude and forms the gain and ramp products.
// ----------------------------------------------------------------------------
module sdl_mul_stage #(
  parameter int AbsW     = 9,
  parameter int RampSpan = 300
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sdl_pkg::ERR_W-1:0]   err_i,
  input  sdl_pkg::cfg_t               cfg_i,
  output logic [sdl_pkg::PM_W-1:0]    pm_o,
  output logic [AbsW+sdl_pkg::RAMP_W-1:0] rp_o,
  output logic                        neg_o,
  output logic                        in_ramp_o
);

  localparam int RpW = AbsW + sdl_pkg::RAMP_W;
  localparam int PmFullW = sdl_pkg::ABS_W + sdl_pkg::BYTE_W;

  logic [sdl_pkg::ABS_W-1:0] abs_err;
  logic [PmFullW-1:0]        pm_full;
  logic [RpW-1:0]            rp_full;
  logic                      in_ramp;

  always_comb begin
    abs_err = err_i[sdl_pkg::ERR_W-1]
            ? (~{err_i[sdl_pkg::ERR_W-1], err_i} + sdl_pkg::ABS_W'(1))
            : {1'b0, err_i};
    pm_full = PmFullW'(abs_err) * PmFullW'(cfg_i.gain);
    rp_full = RpW'(abs_err[AbsW-1:0]) * RpW'(cfg_i.ramp_rate);
    in_ramp = abs_err < sdl_pkg::ABS_W'(RampSpan);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_o      <= pm_full[sdl_pkg::PM_W-1:0];
      rp_o      <= rp_full;
      neg_o     <= err_i[sdl_pkg::ERR_W-1];
      in_ramp_o <= in_ramp;
    end
  end

endmodule

### design/sdl_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter, stage two
// Divides both products by 100 through multiplication by a reciprocal.
// ----------------------------------------------------------------------------
module sdl_div_stage #(
  parameter int AbsW = 9
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [sdl_pkg::PM_W-1:0]        pm_i,
  input  logic [AbsW+sdl_pkg::RAMP_W-1:0] rp_i,
  input  logic                            neg_i,
  input  logic                            in_ramp_i,
  output logic [sdl_pkg::Q_W-1:0]         q_o,
  output logic [AbsW+1:0]                 rq_o,
  output logic                            neg_o,
  output logic                            in_ramp_o
);

  localparam int NW   = AbsW + sdl_pkg::BYTE_W;
  localparam int RpW  = AbsW + sdl_pkg::RAMP_W;
  localparam int S2   = NW + 7;
  localparam int KW2  = NW + 1;
  localparam int PW2  = NW + KW2;
  localparam int RqW  = AbsW + 2;
  localparam longint unsigned K2L = ((64'd1 << S2) + 64'd99) / 64'd100;
  localparam logic [KW2-1:0] K2 = KW2'(K2L);
  localparam int PW1  = sdl_pkg::PM_W + sdl_pkg::PROP_RECIP_W;

  logic [PW1-1:0] pq;
  logic [PW2-1:0] rpq;

  always_comb begin
    pq  = PW1'(pm_i) * PW1'(sdl_pkg::PROP_RECIP);
    rpq = PW2'(rp_i[RpW-1:sdl_pkg::RAMP_FRAC_W]) * PW2'(K2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o       <= pq[sdl_pkg::PROP_SHIFT +: sdl_pkg::Q_W];
      rq_o      <= rpq[S2 +: RqW];
      neg_o     <= neg_i;
      in_ramp_o <= in_ramp_i;
    end
  end

endmodule

### design/sdl_limit_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter, stage three
// Adds the minimum PWM, clamps to the limit and applies the inversion.
// ----------------------------------------------------------------------------
module sdl_limit_stage #(
  parameter int AbsW = 9
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [sdl_pkg::Q_W-1:0]           q_i,
  input  logic [AbsW+1:0]                   rq_i,
  input  logic                              neg_i,
  input  logic                              in_ramp_i,
  input  sdl_pkg::cfg_t                     cfg_i,
  output logic signed [sdl_pkg::DRIVE_W-1:0] drive_o
);

  localparam int RqW  = AbsW + 2;
  localparam int LimW = ((RqW > sdl_pkg::BYTE_W) ? RqW : sdl_pkg::BYTE_W) + 1;
  localparam int CW   = (LimW > sdl_pkg::MAG_W) ? LimW : sdl_pkg::MAG_W;

  logic [sdl_pkg::PWM_W-1:0] qs;
  logic [sdl_pkg::MAG_W-1:0] mag;
  logic [LimW-1:0]           lim;
  logic [CW-1:0]             clamped;
  logic [sdl_pkg::PWM_W-1:0] dmag;
  logic [sdl_pkg::DRIVE_W-1:0] ext;

  always_comb begin
    qs  = (q_i > sdl_pkg::Q_W'(sdl_pkg::PWM_MAX)) ? sdl_pkg::PWM_MAX
                                                  : q_i[sdl_pkg::PWM_W-1:0];
    mag = (qs == '0) ? '0
                     : sdl_pkg::MAG_W'(qs) + sdl_pkg::MAG_W'(cfg_i.min_pwm);
    lim = in_ramp_i ? LimW'(cfg_i.low_pwm) + LimW'(rq_i) : LimW'(cfg_i.high_pwm);
    clamped = (CW'(mag) > CW'(lim)) ? CW'(lim) : CW'(mag);
    dmag = (clamped > CW'(sdl_pkg::PWM_MAX)) ? sdl_pkg::PWM_MAX
                                              : clamped[sdl_pkg::PWM_W-1:0];
    ext  = sdl_pkg::DRIVE_W'(dmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_o <= (neg_i ^ cfg_i.invert_direction) ? $signed(-ext) : $signed(ext);
    end
  end

endmodule

### design/sdl_map_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering drive limiter, stage four
// Applies the valve mapping and splits the drive for the selected driver.
// ----------------------------------------------------------------------------
module sdl_map_stage (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [sdl_pkg::DRIVE_W-1:0] drive_i,
  input  sdl_pkg::cfg_t                      cfg_i,
  output sdl_pkg::out_t                      out_o
);

  logic signed [sdl_pkg::DRIVE_W-1:0] vclamp;
  logic signed [sdl_pkg::DRIVE_W-1:0] vduty;
  logic signed [sdl_pkg::DRIVE_W-1:0] fin;
  logic [sdl_pkg::DRIVE_W-1:0]        mag;
  sdl_pkg::out_t                      res;

  always_comb begin
    priority if (drive_i > sdl_pkg::VALVE_CLAMP) begin
      vclamp = sdl_pkg::VALVE_CLAMP;
    end else if (drive_i < -sdl_pkg::VALVE_CLAMP) begin
      vclamp = -sdl_pkg::VALVE_CLAMP;
    end else begin
      vclamp = drive_i;
    end
    vduty = (vclamp >>> sdl_pkg::VALVE_SHIFT) + sdl_pkg::VALVE_OFFSET;
    fin   = cfg_i.valve_mode ? vduty : drive_i;
    mag   = fin[sdl_pkg::DRIVE_W-1] ? sdl_pkg::DRIVE_W'(-fin) : sdl_pkg::DRIVE_W'(fin);

    res.signed_drive  = fin;
    res.display_value = mag[sdl_pkg::PWM_W-1:0];
    if (cfg_i.driver_select) begin
      res.direction_level   = ~fin[sdl_pkg::DRIVE_W-1];
      res.direction_written = 1'b1;
      res.pwm_left          = mag[sdl_pkg::PWM_W-1:0];
      res.pwm_right         = '0;
      res.right_written     = 1'b0;
    end else begin
      res.direction_level   = 1'b0;
      res.direction_written = 1'b0;
      res.pwm_left          = (fin > 0) ? mag[sdl_pkg::PWM_W-1:0] : '0;
      res.pwm_right         = (fin > 0) ? '0 : mag[sdl_pkg::PWM_W-1:0];
      res.right_written     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_o <= res;
    end
  end

endmodule
